// ===== rtl/fnsa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fnsa_pkg: shared types and constants of the nodal scatter-accumulate block
// Field widths, register and operation codes, reset values and defaults.
// ----------------------------------------------------------------------------
package fnsa_pkg;

    localparam int NODE_W     = 12;
    localparam int VAL_W      = 32;
    localparam int OUT_SUM_W  = 48;
    localparam int OP_W       = 2;
    localparam int DOF_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_FIELDS = 3;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int FRAC_W     = 16;

    localparam int MAX_NODES_DEF = 4096;
    localparam int MAX_DOF_DEF   = 3;
    localparam int SUM_WIDTH_DEF = 48;

    localparam logic signed [VAL_W-1:0] SCALE_RESET = 32'sh0001_0000;
    localparam logic [DOF_W-1:0]        DOF_RESET   = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_ACCUM      = 2'd0,
        OP_READ       = 2'd1,
        OP_READ_CLEAR = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE     = 1'b0,
        CFG_DOF_COUNT = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } t_state;

    // what the merge stage makes of the current row
    typedef struct packed {
        logic accum;
        logic clear;
    } t_upd_ctl;

endpackage : fnsa_pkg
`default_nettype wire

// ===== rtl/fnsa_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fnsa_in_if: request channel of the nodal scatter-accumulate block
// Valid/ready channel carrying an operation, a node index and three values.
// ----------------------------------------------------------------------------
interface fnsa_in_if
    import fnsa_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic [NODE_W-1:0]       node_index;
    logic signed [VAL_W-1:0] value_0;
    logic signed [VAL_W-1:0] value_1;
    logic signed [VAL_W-1:0] value_2;

    modport source (output valid, op, node_index, value_0, value_1, value_2, input ready);
    modport sink   (input valid, op, node_index, value_0, value_1, value_2, output ready);
endinterface : fnsa_in_if
`default_nettype wire

// ===== rtl/fnsa_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fnsa_out_if: result channel of the nodal scatter-accumulate block
// Valid/ready channel carrying a node index, three sums and a saturation flag.
// ----------------------------------------------------------------------------
interface fnsa_out_if
    import fnsa_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [NODE_W-1:0]           out_node;
    logic signed [OUT_SUM_W-1:0] sum_0;
    logic signed [OUT_SUM_W-1:0] sum_1;
    logic signed [OUT_SUM_W-1:0] sum_2;
    logic                        saturated;

    modport source (output valid, out_node, sum_0, sum_1, sum_2, saturated, input ready);
    modport sink   (input valid, out_node, sum_0, sum_1, sum_2, saturated, output ready);
endinterface : fnsa_out_if
`default_nettype wire

// ===== rtl/fnsa_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fnsa_lane: one degree-of-freedom lane
// Registered scale * value product, floor to Q32.16, saturating add to a sum.
// ----------------------------------------------------------------------------
module fnsa_lane
    import fnsa_pkg::*;
#(
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic signed [VAL_W-1:0]     i_scale,
    input  wire logic signed [VAL_W-1:0]     i_value,
    input  wire logic signed [SUM_WIDTH-1:0] i_acc,
    input  wire logic                        i_en,
    output      logic signed [SUM_WIDTH-1:0] o_sum,
    output      logic                        o_sat
);
    localparam int P_W = PROD_W - FRAC_W;
    localparam int EXT = ((SUM_WIDTH > P_W) ? SUM_WIDTH : P_W) + 1;
    localparam logic signed [EXT-1:0] HI = {{(EXT-SUM_WIDTH+1){1'b0}}, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [EXT-1:0] LO = {{(EXT-SUM_WIDTH+1){1'b1}}, {(SUM_WIDTH-1){1'b0}}};

    logic signed [PROD_W-1:0] r_prod;
    logic signed [P_W-1:0]    w_p;
    logic signed [EXT-1:0]    w_full;

    always_ff @(posedge i_clk) begin
        r_prod <= i_scale * i_value;
    end

    // arithmetic shift floors toward minus infinity
    assign w_p    = P_W'(r_prod >>> FRAC_W);
    assign w_full = EXT'(i_acc) + EXT'(w_p);

    always_comb begin
        o_sum = i_acc;
        o_sat = 1'b0;
        if (i_en) begin
            if (w_full > HI) begin
                o_sum = SUM_WIDTH'(HI);
                o_sat = 1'b1;
            end else if (w_full < LO) begin
                o_sum = SUM_WIDTH'(LO);
                o_sat = 1'b1;
            end else begin
                o_sum = SUM_WIDTH'(w_full);
            end
        end
    end
endmodule : fnsa_lane
`default_nettype wire

// ===== rtl/fnsa_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fnsa_merge: lane merge stage
// Pack lane sums and the combined saturation mark into one store row; zero row otherwise.
// ----------------------------------------------------------------------------
module fnsa_merge
    import fnsa_pkg::*;
#(
    parameter int MAX_DOF   = MAX_DOF_DEF,
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
    input  wire t_upd_ctl                         i_ctl,
    input  wire logic                             i_old_sat,
    input  wire logic [MAX_DOF*SUM_WIDTH-1:0]     i_lane_sum,
    input  wire logic [MAX_DOF-1:0]               i_lane_sat,
    output      logic [MAX_DOF*SUM_WIDTH:0]       o_row
);
    always_comb begin
        if (i_ctl.clear || !i_ctl.accum) begin
            o_row = '0;
        end else begin
            o_row = {i_old_sat | (|i_lane_sat), i_lane_sum};
        end
    end
endmodule : fnsa_merge
`default_nettype wire

// ===== rtl/fnsa_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fnsa_store: nodal row memory
// One row per node; one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fnsa_store
    import fnsa_pkg::*;
#(
    parameter int DEPTH = MAX_NODES_DEF,
    parameter int ROW_W = MAX_DOF_DEF * SUM_WIDTH_DEF + 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [ROW_W-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output      logic [ROW_W-1:0] o_rdata
);
    logic [ROW_W-1:0] r_mem [DEPTH];
    logic [ROW_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule : fnsa_store
`default_nettype wire

// ===== rtl/fem_nodal_scatter_accumulate.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fem_nodal_scatter_accumulate: scatter-add of element contributions per node
// Scales up to three Q16.16 values per beat and adds them into a node's
// saturating Q32.16 sums; read beats return a node's sums and its mark.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  request channel (valid/ready). op 0 accumulates value_0..2 into
//         node_index, op 1 reads the node, op 2 reads and then zeroes it.
//         op 3 and accumulates to nodes beyond MAX_NODES are dropped.
//   o_out result channel, one beat per read or read-and-clear beat.
//   i_cfg_we/i_cfg_index/i_cfg_data write scale (index 0) and dof_count
//   (index 1) in a single cycle; write only while the block is idle.
// Sequence: a request beat goes through accept, store read, update and
//   write-back, the read-modify-write on the single row memory; no new
//   beat is taken until it ends. The three lanes scale and add in parallel in that pass.
// Result: a read's beat is loaded into the output register as its update ends.
// Stall: a waiting result holds in the output register; a read that finds
//   the register still occupied holds in the update step until it drains.
// Reset: after i_rst_n the store is swept to zero, one row a cycle, over
//   min(MAX_NODES, 4096) rows; i_in.ready stays low meanwhile while
//   configuration writes are still taken.
// ----------------------------------------------------------------------------
module fem_nodal_scatter_accumulate
    import fnsa_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_DOF   = MAX_DOF_DEF,
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    fnsa_in_if.sink                    i_in,
    fnsa_out_if.source                 o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);
    // node_index is 12 bits wide, so no more rows than that can be addressed
    localparam int DEPTH = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
    localparam int AW    = $clog2(DEPTH);
    localparam int ROW_W = MAX_DOF * SUM_WIDTH + 1;

    // control
    t_state r_state, n_state;
    logic [AW-1:0] r_clr_cnt;

    // configuration
    logic signed [VAL_W-1:0] r_scale;
    logic [DOF_W-1:0]        r_dof;

    // request held for the duration of its pass
    logic [OP_W-1:0]         r_op;
    logic [NODE_W-1:0]       r_node;
    logic                    r_node_ok;
    logic signed [VAL_W-1:0] r_value [MAX_DOF];

    // result register
    logic                        r_out_valid;
    logic [NODE_W-1:0]           r_out_node;
    logic signed [OUT_SUM_W-1:0] r_out_sum [NUM_FIELDS];
    logic                        r_out_sat;

    logic signed [VAL_W-1:0]     w_in_val [NUM_FIELDS];
    logic [ROW_W-1:0]            w_rdata;
    logic [ROW_W-1:0]            w_row;
    logic [ROW_W-1:0]            w_wdata;
    logic [AW-1:0]               w_waddr;
    logic                        w_we;
    logic [MAX_DOF*SUM_WIDTH-1:0] w_lane_sum;
    logic [MAX_DOF-1:0]          w_lane_sat;
    logic signed [OUT_SUM_W-1:0] w_rd_sum [NUM_FIELDS];
    logic                        w_accept;
    logic                        w_is_read;
    logic                        w_out_free;
    logic                        w_finish;
    logic                        w_load_out;
    t_upd_ctl                    w_ctl;

    assign w_in_val[0] = i_in.value_0;
    assign w_in_val[1] = i_in.value_1;
    assign w_in_val[2] = i_in.value_2;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_is_read  = (r_op == OP_READ) || (r_op == OP_READ_CLEAR);
    assign w_out_free = !r_out_valid || o_out.ready;
    // a read may leave the update step only once the result register frees up
    assign w_finish   = (r_state == ST_UPDATE) && (!w_is_read || w_out_free);
    assign w_load_out = w_finish && w_is_read;

    assign w_ctl.accum = (r_op == OP_ACCUM);
    assign w_ctl.clear = (r_op == OP_READ_CLEAR);

    // ---------------------------------------------------------------- FSM
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_cnt == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (w_finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------ configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
            r_dof   <= DOF_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCALE:     r_scale <= i_cfg_data[VAL_W-1:0];
                CFG_DOF_COUNT: r_dof   <= i_cfg_data[DOF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------ request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= i_in.op;
            r_node    <= i_in.node_index;
            r_node_ok <= (32'(i_in.node_index) < MAX_NODES);
        end
    end

    // ------------------------------------------------------------- lanes
    for (genvar d = 0; d < MAX_DOF; d++) begin : g_lane
        always_ff @(posedge i_clk) begin
            if (w_accept) begin
                r_value[d] <= w_in_val[d];
            end
        end

        fnsa_lane #(
            .SUM_WIDTH (SUM_WIDTH)
        ) u_lane (
            .i_clk   (i_clk),
            .i_scale (r_scale),
            .i_value (r_value[d]),
            .i_acc   (w_rdata[d*SUM_WIDTH +: SUM_WIDTH]),
            .i_en    (r_dof > DOF_W'(d)),
            .o_sum   (w_lane_sum[d*SUM_WIDTH +: SUM_WIDTH]),
            .o_sat   (w_lane_sat[d])
        );
    end

    fnsa_merge #(
        .MAX_DOF   (MAX_DOF),
        .SUM_WIDTH (SUM_WIDTH)
    ) u_merge (
        .i_ctl      (w_ctl),
        .i_old_sat  (w_rdata[ROW_W-1]),
        .i_lane_sum (w_lane_sum),
        .i_lane_sat (w_lane_sat),
        .o_row      (w_row)
    );

    // ------------------------------------------------------------- store
    // clear sweep writes zero rows; an accumulate or read-and-clear writes back on its last cycle
    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_cnt;
            w_wdata = '0;
        end else begin
            w_we    = w_finish && r_node_ok && (w_ctl.accum || w_ctl.clear);
            w_waddr = r_node[AW-1:0];
            w_wdata = w_row;
        end
    end

    fnsa_store #(
        .DEPTH (DEPTH),
        .ROW_W (ROW_W),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_node[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------------------ results
    // stored sums come back sign-extended or cut to the 48-bit field
    for (genvar d = 0; d < NUM_FIELDS; d++) begin : g_rd
        if (d < MAX_DOF) begin : g_used
            logic signed [SUM_WIDTH-1:0] w_lane_val;
            assign w_lane_val = w_rdata[d*SUM_WIDTH +: SUM_WIDTH];
            assign w_rd_sum[d] = r_node_ok ? OUT_SUM_W'(w_lane_val) : '0;
        end else begin : g_absent
            assign w_rd_sum[d] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_node <= r_node;
            r_out_sum  <= w_rd_sum;
            r_out_sat  <= r_node_ok && w_rdata[ROW_W-1];
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_node  = r_out_node;
    assign o_out.sum_0     = r_out_sum[0];
    assign o_out.sum_1     = r_out_sum[1];
    assign o_out.sum_2     = r_out_sum[2];
    assign o_out.saturated = r_out_sat;
endmodule : fem_nodal_scatter_accumulate
`default_nettype wire
